/* hw/rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg - shared types and constants for integer_to_ascii_radix
// Field widths, character codes, the job word passed from the front end to
// the back end, and the digit-to-glyph mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Default field cap (digits plus spaces); legal range 21..63
  localparam int MAX_FIELD_CHARS_DEF = 49;

  // Field widths
  localparam int VALUE_W     = 64;
  localparam int BASE_W      = 6;
  localparam int PAD_W       = 6;
  localparam int CHAR_W      = 7;
  // Digit / space counters: the cap never exceeds 63, so six bits hold it
  localparam int CNT_W       = 6;
  // One quotient bit per cycle in the divider
  localparam int DIV_CNT_W   = $clog2(VALUE_W);

  // Stream word widths (whole bytes)
  localparam int IN_FIELDS_W  = VALUE_W + BASE_W + PAD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((CHAR_W + 7) / 8) * 8;

  // Base saturation limits
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h5A;

  // Classified number, front end to back end
  typedef struct packed {
    logic [VALUE_W-1:0] mag;   // magnitude to convert
    logic               neg;   // print a leading minus
    logic [BASE_W-1:0]  base;  // saturated radix, 2..36
    logic [CNT_W-1:0]   pad;   // pad width clamped to the field cap
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  // Digit value to ASCII: 0-9 then A-Z
  function automatic logic [CHAR_W-1:0] glyph(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < BASE_W'(10)) begin
      glyph = CHAR_ZERO + dx;
    end else if (d < BASE_MAX) begin
      glyph = CHAR_A + (dx - CHAR_W'(10));
    end else begin
      glyph = CHAR_ZERO;
    end
  endfunction

endpackage

/* hw/rtl/itoa_ram.sv */
// ----------------------------------------------------------------------------
// itoa_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 49
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* hw/rtl/itoa_front.sv */
// ----------------------------------------------------------------------------
// itoa_front - input word classifier
// Unpacks the input word, finds the sign, takes the magnitude, saturates
// the base and clamps the pad width to the field cap.
// ----------------------------------------------------------------------------
module itoa_front #(
  parameter int MAX_FIELD_CHARS = itoa_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic [itoa_pkg::VALUE_W-1:0] value,
  input  logic                         treat_signed,
  input  logic [itoa_pkg::BASE_W-1:0]  base,
  input  logic [itoa_pkg::PAD_W-1:0]   pad_width,
  output itoa_pkg::job_t               job
);
  import itoa_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_FIELD_CHARS);

  logic neg;

  // sign and magnitude; the most negative value negates to its own pattern,
  // which read unsigned is the true magnitude
  assign neg = treat_signed & value[VALUE_W-1];

  always_comb begin
    job.neg = neg;
    job.mag = neg ? (VALUE_W'(0) - value) : value;
    // base saturation
    if (base < BASE_MIN) begin
      job.base = BASE_MIN;
    end else if (base > BASE_MAX) begin
      job.base = BASE_MAX;
    end else begin
      job.base = base;
    end
    // pad clamp to field cap
    if (CNT_W'(pad_width) > CAP) begin
      job.pad = CAP;
    end else begin
      job.pad = CNT_W'(pad_width);
    end
  end

endmodule

/* hw/rtl/itoa_queue.sv */
// ----------------------------------------------------------------------------
// itoa_queue - two-entry job queue
// Decouples the input handshake from the converter so a new word can be
// taken while a number is still being divided or printed.
// ----------------------------------------------------------------------------
module itoa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  itoa_pkg::job_t    push_job,
  output logic              full,
  input  logic              pop,
  output itoa_pkg::q_head_t head
);
  import itoa_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.job   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hw/rtl/itoa_back.sv */
// ----------------------------------------------------------------------------
// itoa_back - digit generator and character sequencer
// Restoring divider (one quotient bit a cycle) produces digits least
// significant first into the digit store, then the sign, spaces and digits
// are sent out through a single output register.
// ----------------------------------------------------------------------------
module itoa_back #(
  parameter int MAX_FIELD_CHARS = itoa_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  itoa_pkg::q_head_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [itoa_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);
  import itoa_pkg::*;

  localparam int               AW       = $clog2(MAX_FIELD_CHARS);
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(MAX_FIELD_CHARS);
  localparam logic [DIV_CNT_W-1:0] BIT_LAST = DIV_CNT_W'(VALUE_W - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SIGN  = 6'b000100,
    S_PAD   = 6'b001000,
    S_RD    = 6'b010000,
    S_DIGIT = 6'b100000
  } back_state_t;

  back_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [BASE_W-1:0]    rem_r, rem_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0]     pad_r, pad_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] bit_r, bit_nxt;
  logic [CNT_W-1:0]     nd_r, nd_nxt;
  logic [CNT_W-1:0]     sp_r, sp_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [BASE_W:0]      trial, diff;
  logic                 ge;
  logic [BASE_W-1:0]    rem_step;
  logic [VALUE_W-1:0]   quo_step;
  logic [CNT_W-1:0]     nd_inc, idx_m1;
  logic                 out_free;
  logic                 ram_we, ram_re;
  logic [BASE_W-1:0]    ram_rdata;

  // one restoring-division step
  assign trial    = {rem_r, quo_r[VALUE_W-1]};
  assign diff     = trial - {1'b0, base_r};
  assign ge       = (trial >= {1'b0, base_r});
  assign rem_step = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
  assign quo_step = {quo_r[VALUE_W-2:0], ge};
  assign nd_inc   = nd_r + CNT_W'(1);
  assign idx_m1   = idx_r - CNT_W'(1);

  // output register can take a new character
  assign out_free = !out_valid_r || out_ready;

  // digit store
  itoa_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_FIELD_CHARS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nd_r[AW-1:0]),
    .wdata (rem_step),
    .re    (ram_re),
    .raddr (idx_m1[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    pad_nxt       = pad_r;
    neg_nxt       = neg_r;
    bit_nxt       = bit_r;
    nd_nxt        = nd_r;
    sp_nxt        = sp_r;
    idx_nxt       = idx_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          quo_nxt   = head.job.mag;
          base_nxt  = head.job.base;
          pad_nxt   = head.job.pad;
          neg_nxt   = head.job.neg;
          rem_nxt   = '0;
          bit_nxt   = '0;
          nd_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        bit_nxt = bit_r + DIV_CNT_W'(1);
        if (bit_r == BIT_LAST) begin
          // digit done: store remainder; stop if quotient zero or store full
          ram_we  = 1'b1;
          nd_nxt  = nd_inc;
          rem_nxt = '0;
          bit_nxt = '0;
          if ((quo_step == '0) || (nd_inc == CAP)) begin
            idx_nxt = nd_inc;
            sp_nxt  = (pad_r > nd_inc) ? (pad_r - nd_inc) : '0;
            if (neg_r) begin
              state_nxt = S_SIGN;
            end else if (pad_r > nd_inc) begin
              state_nxt = S_PAD;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = (sp_r != '0) ? S_PAD : S_RD;
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_SPACE;
          out_last_nxt  = 1'b0;
          sp_nxt        = sp_r - CNT_W'(1);
          if (sp_r == CNT_W'(1)) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        // fetch the next digit, most significant first
        ram_re    = 1'b1;
        state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = glyph(ram_rdata);
          out_last_nxt  = (idx_r == CNT_W'(1));
          idx_nxt       = idx_m1;
          state_nxt     = (idx_r == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
      quo_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
      quo_r       <= quo_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    pad_r      <= pad_nxt;
    neg_r      <= neg_nxt;
    bit_r      <= bit_nxt;
    sp_r       <= sp_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

/* hw/rtl/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix - 64-bit integer to ASCII text in radix 2..36
// Prints one number as a run of characters: optional minus, left padding
// spaces, then digits most significant first; the final one has tlast.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word per number (value, base, pad width in tdata,
//   signed flag in tuser). Output stream: one word per character, ASCII in
//   tdata[6:0], tlast on the final character of the number.
//   Digits are produced by a restoring divider, one quotient bit a cycle;
//   the last step of each digit stores it. A number is popped from the
//   queue, divided, then sent as sign and spaces, each one step, and as
//   digits, each a read step then an output step, with the output waiting
//   whenever the receiver stalls. The divider loop sets the rate.
//   A two-entry queue sits in front of the converter, so up to two numbers
//   are taken while one is being converted. The output register holds its
//   character while out_tready is low; the sequencer waits, and the divider
//   of the next number proceeds once its digits are no longer needed.
//   Reset clears the queue, the sequencer and the output valid; the digit
//   store needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int MAX_FIELD_CHARS = itoa_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [itoa_pkg::IN_TDATA_W-1:0]  in_tdata,  // value[63:0], base[69:64],
                                                     // pad_width[75:70], zero fill
  input  logic                             in_tuser,  // treat_signed
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [itoa_pkg::OUT_TDATA_W-1:0] out_tdata, // character[6:0], zero fill
  output logic                             out_tlast  // last
);
  import itoa_pkg::*;

  job_t    front_job;
  q_head_t q_head;
  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic [CHAR_W-1:0] out_char;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify incoming word
  itoa_front #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_front (
    .value        (in_tdata[VALUE_W-1:0]),
    .treat_signed (in_tuser),
    .base         (in_tdata[VALUE_W +: BASE_W]),
    .pad_width    (in_tdata[VALUE_W+BASE_W +: PAD_W]),
    .job          (front_job)
  );

  // job queue
  itoa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // conversion and output
  itoa_back #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // converter only takes a job the queue actually holds
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("job taken from an empty queue");

  // every character is a minus, a space, a decimal digit or a letter
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_char == CHAR_MINUS) || (out_char == CHAR_SPACE) ||
                    ((out_char >= CHAR_ZERO) && (out_char <= CHAR_NINE)) ||
                    ((out_char >= CHAR_A) && (out_char <= CHAR_Z))))
    else $error("illegal character on output");

  // sign and padding are never the final character
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> ((out_char != CHAR_MINUS) &&
                                   (out_char != CHAR_SPACE)))
    else $error("number ended on a sign or space");

  // output idle right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

/* verif/tb_integer_to_ascii_radix.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix - self-checking bench for integer_to_ascii_radix
// Feeds numbers (directed corner values, then random ones) through the input
// stream with random gaps, predicts the character run of each accepted word,
// and checks every output word in order against it. The receiver stalls at
// random and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix;
  import itoa_pkg::*;

  localparam int FIELD_CAP    = MAX_FIELD_CHARS_DEF;
  localparam int RANDOM_NUMS  = 120;
  localparam int HOLD_CYCLES  = 5000;
  localparam int DRAIN_CYCLES = 200;

  // One number to print
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               sgn;
    logic [BASE_W-1:0]  base;
    logic [PAD_W-1:0]   pad;
  } num_t;

  // One printed character
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  num_t       nums_pending[$];
  text_char_t chars_due[$];
  num_t       num_on_bus;
  int         nums_total;
  int         nums_taken = 0;
  int         err_count = 0;
  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;
  logic       hold_off = 1'b0;
  int         tx_gap = 0;
  int         tx_burst = 0;
  int         rx_wait = 0;
  int         rx_burst = 0;

  integer_to_ascii_radix u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Wait before the next word, with occasional runs of no gaps
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst = $urandom_range(5, 25);
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    if (d < 10) return CHAR_ZERO + CHAR_W'(d);
    return CHAR_A + CHAR_W'(d - 10);
  endfunction

  // Expected character run of one number: sign, padding, digits
  task automatic predict_text(input num_t n);
    logic [VALUE_W-1:0] mag;
    logic [BASE_W-1:0]  radix;
    logic [BASE_W-1:0]  digs[FIELD_CAP];
    logic               neg;
    int                 nd;
    int                 width;
    text_char_t         c;
    neg   = n.sgn && n.value[VALUE_W-1];
    radix = (n.base < 2) ? BASE_W'(2) : (n.base > 36) ? BASE_W'(36) : n.base;
    mag   = neg ? -n.value : n.value;
    nd    = 0;
    // low digits first; high ones beyond the cap are dropped
    do begin
      digs[nd] = BASE_W'(mag % VALUE_W'(radix));
      mag      = mag / VALUE_W'(radix);
      nd++;
    end while (mag != 0 && nd < FIELD_CAP);
    width = (int'(n.pad) > nd) ? int'(n.pad) : nd;
    if (width > FIELD_CAP) width = FIELD_CAP;
    c.last = 1'b0;
    if (neg) begin
      c.code = CHAR_MINUS;
      chars_due.push_back(c);
    end
    c.code = CHAR_SPACE;
    repeat (width - nd) chars_due.push_back(c);
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = digit_char(digs[i]);
      c.last = (i == 0);
      chars_due.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic num_t make_num(input logic [VALUE_W-1:0] v, input logic s,
                                    input int b, input int p);
    num_t n;
    n.value = v;
    n.sgn   = s;
    n.base  = BASE_W'(b);
    n.pad   = PAD_W'(p);
    return n;
  endfunction

  // Random number: magnitudes of random bit length, some corner patterns
  function automatic num_t random_num();
    num_t n;
    int   bits;
    bits    = $urandom_range(1, 64);
    n.value = {$urandom, $urandom};
    if (bits < 64) n.value &= (64'd1 << bits) - 64'd1;
    n.sgn = 1'($urandom_range(0, 1));
    if (n.sgn && $urandom_range(0, 2) == 0) n.value = -n.value;
    case ($urandom_range(0, 15))
      0: n.value = '0;
      1: n.value = {1'b1, 63'd0};
      2: n.value = '1;
      default: ;
    endcase
    n.base = ($urandom_range(0, 7) == 0) ? BASE_W'($urandom_range(0, 63))
                                         : BASE_W'($urandom_range(2, 36));
    n.pad  = ($urandom_range(0, 4) == 0) ? PAD_W'($urandom_range(0, 63))
                                         : PAD_W'($urandom_range(0, 20));
    return n;
  endfunction

  // Sender: words change on the falling edge
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (nums_pending.size() > 0) begin
        num_on_bus = nums_pending.pop_front();
        in_tdata   <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                       num_on_bus.pad, num_on_bus.base, num_on_bus.value};
        in_tuser   <= num_on_bus.sgn;
        in_tvalid  <= 1'b1;
        tx_gap = draw_gap(tx_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per word, plus the long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) rx_wait = draw_gap(rx_burst);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: sample handshakes on the rising edge
  always @(posedge clk) begin
    text_char_t exp_c;
    in_taken  <= in_tvalid && in_tready;
    out_taken <= out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word 0x%02h last %b", out_tdata, out_tlast));
        end else begin
          exp_c = chars_due.pop_front();
          if (out_tdata !== OUT_TDATA_W'(exp_c.code))
            report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                      out_tdata, exp_c.code));
          if (out_tlast !== exp_c.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, exp_c.last));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_text(num_on_bus);
        nums_taken <= nums_taken + 1;
      end
    end
  end

  // Long receiver hold-off once traffic is under way
  initial begin
    wait (nums_taken >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run time limit
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    // zero, in both modes
    nums_pending.push_back(make_num(64'd0, 1'b0, 10, 0));
    nums_pending.push_back(make_num(64'd0, 1'b1, 2, 5));
    // most negative value, signed and unsigned
    nums_pending.push_back(make_num({1'b1, 63'd0}, 1'b1, 10, 0));
    nums_pending.push_back(make_num({1'b1, 63'd0}, 1'b0, 10, 0));
    // most negative in binary: sign plus a full capped field
    nums_pending.push_back(make_num({1'b1, 63'd0}, 1'b1, 2, 0));
    // all ones as -1 and as the largest unsigned value
    nums_pending.push_back(make_num('1, 1'b1, 16, 3));
    nums_pending.push_back(make_num('1, 1'b0, 2, 0));
    nums_pending.push_back(make_num('1, 1'b0, 36, 0));
    nums_pending.push_back(make_num({1'b0, {63{1'b1}}}, 1'b1, 10, 0));
    // base saturation below two and above thirty-six
    nums_pending.push_back(make_num(64'd5, 1'b0, 0, 0));
    nums_pending.push_back(make_num(64'd6, 1'b0, 1, 4));
    nums_pending.push_back(make_num(64'd1295, 1'b0, 37, 0));
    nums_pending.push_back(make_num(64'd1296, 1'b1, 63, 2));
    // padding up to, at and beyond the cap
    nums_pending.push_back(make_num(64'd7, 1'b0, 10, FIELD_CAP));
    nums_pending.push_back(make_num(-64'd12345, 1'b1, 10, 63));
    nums_pending.push_back(make_num(64'd123456789, 1'b0, 8, 20));
    nums_pending.push_back(make_num(64'd35, 1'b0, 36, 1));
    nums_pending.push_back(make_num(64'hDEAD_BEEF_0123_4567, 1'b1, 16, 17));
    nums_pending.push_back(make_num(64'd1, 1'b0, 2, 1));
    nums_pending.push_back(make_num(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 3, 42));
    for (int i = 0; i < RANDOM_NUMS; i++) nums_pending.push_back(random_num());
    nums_total = nums_pending.size();

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all numbers in, all characters out, then watch for strays
    while (nums_taken < nums_total) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
